>>> sv/eas_pkg.sv
package eas_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DOY_W   = 9;

    localparam logic [MONTH_W-1:0] MONTH_JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MARCH    = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APRIL    = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY      = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUNE     = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_DECEMBER = 4'd12;

    // easter sunday as left by the computus pipeline
    typedef struct packed {
        logic               leap;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } eas_easter_t;

    // one calendar date, month in the low bits
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
    } eas_date_t;

    // all five dates, carnival in the low bits
    typedef struct packed {
        eas_date_t whitsun;
        eas_date_t ascension;
        eas_date_t easter;
        eas_date_t holy_friday;
        eas_date_t carnival;
    } eas_feasts_t;

    // days of the year that lie before the first of the given month
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
        logic [DOY_W-1:0] days;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        if (month > MONTH_FEBRUARY && month <= MONTH_DECEMBER) begin
            days = days + DOY_W'(leap);
        end
        return days;
    endfunction

    // month that holds a day of the year, last month takes any overflow
    function automatic logic [MONTH_W-1:0] month_of(input logic [7:0] doy, input logic leap);
        logic [MONTH_W-1:0] month;
        month = MONTH_JANUARY;
        for (int k = 2; k <= 12; k++) begin
            if ({1'b0, doy} > days_before(MONTH_W'(k), leap)) begin
                month = month + 4'd1;
            end
        end
        return month;
    endfunction

endpackage

>>> sv/easter_feast_dates_unit.sv
// Easter and dependent feast dates for a Gregorian year.
// Input channel s_*: one item per year, s_tdata[13:0] holds the year.
// Result channel m_*: one item per input item carrying five dates
// (carnival, holy friday, easter, ascension, whitsun), each as month and day.
// The datapath is a 13-stage pipeline: 9 stages of computus arithmetic
// (reciprocal multiplies for the divisions by 100, 19, 25, 3, 30 and 7),
// then 4 stages that form the day of the year and convert each offset date
// back to month and day through the cumulative month-length table.
// A result is offered once its item has passed through all the stages.
// Throughput: one item per cycle as long as m_tready stays high.
// Every stage carries a valid bit; ready ripples back through empty stages,
// so bubbles are squeezed out and input keeps flowing while results wait.
// When m_tready stays low the pipeline fills and then holds every item;
// nothing is dropped or repeated, and s_tready falls once all stages are full.
// Reset (aresetn low at a clock edge) empties the pipeline; no other state.
module easter_feast_dates_unit import eas_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [13:0] year, [15:14] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // carnival_month, carnival_day, holy_friday_month,
                                   // holy_friday_day, easter_month_out, easter_day_out,
                                   // ascension_month, ascension_day, whitsun_month,
                                   // whitsun_day, each month 4 and day 5 bits; zero pad
);

    logic        comp_valid;
    logic        comp_ready;
    eas_easter_t comp_easter;
    eas_feasts_t feasts;

    // easter sunday from the year
    eas_computus u_computus (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_year    (s_tdata[YEAR_W-1:0]),
        .out_valid  (comp_valid),
        .out_ready  (comp_ready),
        .out_easter (comp_easter)
    );

    // offset feasts and month/day conversion
    eas_feast_dates u_feast_dates (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (comp_valid),
        .in_ready   (comp_ready),
        .in_easter  (comp_easter),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_feasts (feasts)
    );

    // pack the five dates, carnival lowest, pad to whole bytes
    assign m_tdata = {3'b000, feasts};

endmodule

>>> sv/eas_computus.sv
module eas_computus import eas_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [YEAR_W-1:0] in_year,
    output logic              out_valid,
    input  logic              out_ready,
    output eas_easter_t       out_easter
);

    localparam int NST = 9;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    // stage registers
    logic [YEAR_W-1:0] y_s0_reg;
    logic [YEAR_W-1:0] y_s1_reg;
    logic [7:0]        b_s1_reg;
    logic [9:0]        q19_s1_reg;
    logic [4:0]        a_s2_reg;
    logic [7:0]        b_s2_reg;
    logic [6:0]        c_s2_reg;
    logic [2:0]        f_s2_reg;
    logic [1:0]        ylo_s2_reg;
    logic [4:0]        a_s3_reg;
    logic [7:0]        b_s3_reg;
    logic [6:0]        c_s3_reg;
    logic [5:0]        g_s3_reg;
    logic              leap_s3_reg;
    logic [9:0]        x_s4_reg;
    logic [4:0]        qh_s4_reg;
    logic [4:0]        a_s4_reg;
    logic [6:0]        c_s4_reg;
    logic [1:0]        e_s4_reg;
    logic              leap_s4_reg;
    logic [4:0]        h_s5_reg;
    logic [6:0]        lx_s5_reg;
    logic [4:0]        a_s5_reg;
    logic              leap_s5_reg;
    logic [4:0]        h_s6_reg;
    logic [6:0]        lx_s6_reg;
    logic [3:0]        ql_s6_reg;
    logic [4:0]        a_s6_reg;
    logic              leap_s6_reg;
    logic [4:0]        h_s7_reg;
    logic [2:0]        l_s7_reg;
    logic              mge_s7_reg;
    logic              leap_s7_reg;
    eas_easter_t       easter_s8_reg;

    // next values
    logic [26:0]  prod_b;
    logic [29:0]  prod_19;
    logic [13:0]  hund;
    logic [13:0]  n19;
    logic [8:0]   bp8;
    logic [14:0]  prod_f;
    logic [6:0]   c_next;
    logic [4:0]   a_next;
    logic [8:0]   gx;
    logic [15:0]  prod_g;
    logic         leap_next;
    logic [9:0]   x_next;
    logic [20:0]  prod_h;
    logic [9:0]   h30;
    logic [4:0]   h_next;
    logic [7:0]   lx_wide;
    logic [17:0]  prod_l;
    logic [6:0]   l7;
    logic [2:0]   l_next;
    logic [9:0]   mx;
    logic [7:0]   base;
    eas_easter_t  easter_next;

    // ready ripples back through empty stages
    always_comb begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready   = rdy[0];
    assign out_valid  = v_reg[NST-1];
    assign out_easter = easter_s8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // century and golden number by reciprocal multiply
    assign prod_b  = 27'(y_s0_reg) * 27'd5243;
    assign prod_19 = 30'(y_s0_reg) * 30'd55189;

    // remainders, and (b + 8) / 25
    assign hund   = 14'(b_s1_reg) * 14'd100;
    assign n19    = 14'(q19_s1_reg) * 14'd19;
    assign c_next = 7'(y_s1_reg - hund);
    assign a_next = 5'(y_s1_reg - n19);
    assign bp8    = 9'(b_s1_reg) + 9'd8;
    assign prod_f = 15'(bp8) * 15'd41;

    // (b - f + 1) / 3 and the leap-year rule
    assign gx     = 9'(b_s2_reg) - 9'(f_s2_reg) + 9'd1;
    assign prod_g = 16'(gx) * 16'd171;
    assign leap_next = (c_s2_reg == 7'd0) ? (b_s2_reg[1:0] == 2'd0) : (ylo_s2_reg == 2'd0);

    // epact sum and its quotient by 30
    assign x_next = 10'(a_s3_reg) * 10'd19 + 10'(b_s3_reg) - 10'(b_s3_reg[7:2])
                  - 10'(g_s3_reg) + 10'd15;
    assign prod_h = 21'(x_next) * 21'd1093;

    // epact, then the weekday sum
    assign h30     = 10'(qh_s4_reg) * 10'd30;
    assign h_next  = 5'(x_s4_reg - h30);
    assign lx_wide = 8'd32 + {5'd0, e_s4_reg, 1'b0} + {1'b0, c_s4_reg[6:2], 1'b0}
                   - 8'(h_next) - 8'(c_s4_reg[1:0]);

    // weekday sum over 7
    assign prod_l = 18'(lx_s5_reg) * 18'd147;

    // weekday correction and the late-epact test
    assign l7     = 7'(ql_s6_reg) * 7'd7;
    assign l_next = 3'(lx_s6_reg - l7);
    assign mx     = 10'(a_s6_reg) + 10'(h_s6_reg) * 10'd11 + 10'(l_next) * 10'd22;

    // easter as month and day
    always_comb begin
        base = 8'(h_s7_reg) + 8'(l_s7_reg) + 8'd114 - (mge_s7_reg ? 8'd7 : 8'd0);
        easter_next.leap = leap_s7_reg;
        if (base >= 8'd124) begin
            easter_next.month = MONTH_APRIL;
            easter_next.day   = 5'(base - 8'd123);
        end else begin
            easter_next.month = MONTH_MARCH;
            easter_next.day   = 5'(base - 8'd92);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            y_s0_reg <= in_year;
        end
        if (rdy[1]) begin
            y_s1_reg   <= y_s0_reg;
            b_s1_reg   <= prod_b[26:19];
            q19_s1_reg <= prod_19[29:20];
        end
        if (rdy[2]) begin
            a_s2_reg   <= a_next;
            b_s2_reg   <= b_s1_reg;
            c_s2_reg   <= c_next;
            f_s2_reg   <= prod_f[12:10];
            ylo_s2_reg <= y_s1_reg[1:0];
        end
        if (rdy[3]) begin
            a_s3_reg    <= a_s2_reg;
            b_s3_reg    <= b_s2_reg;
            c_s3_reg    <= c_s2_reg;
            g_s3_reg    <= prod_g[14:9];
            leap_s3_reg <= leap_next;
        end
        if (rdy[4]) begin
            x_s4_reg    <= x_next;
            qh_s4_reg   <= prod_h[19:15];
            a_s4_reg    <= a_s3_reg;
            c_s4_reg    <= c_s3_reg;
            e_s4_reg    <= b_s3_reg[1:0];
            leap_s4_reg <= leap_s3_reg;
        end
        if (rdy[5]) begin
            h_s5_reg    <= h_next;
            lx_s5_reg   <= lx_wide[6:0];
            a_s5_reg    <= a_s4_reg;
            leap_s5_reg <= leap_s4_reg;
        end
        if (rdy[6]) begin
            h_s6_reg    <= h_s5_reg;
            lx_s6_reg   <= lx_s5_reg;
            ql_s6_reg   <= prod_l[13:10];
            a_s6_reg    <= a_s5_reg;
            leap_s6_reg <= leap_s5_reg;
        end
        if (rdy[7]) begin
            h_s7_reg    <= h_s6_reg;
            l_s7_reg    <= l_next;
            mge_s7_reg  <= (mx >= 10'd451);
            leap_s7_reg <= leap_s6_reg;
        end
        if (rdy[8]) begin
            easter_s8_reg <= easter_next;
        end
    end

    // epact and weekday stay inside their residue ranges
    a_epact_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[5] |-> h_s5_reg < 5'd30)
        else $error("epact out of range");

    a_weekday_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[7] |-> l_s7_reg < 3'd7)
        else $error("weekday residue out of range");

    a_easter_month: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_easter.month == MONTH_MARCH || out_easter.month == MONTH_APRIL))
        else $error("easter outside march and april");

    a_easter_day: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> out_easter.day != 5'd0)
        else $error("easter day zero");

endmodule

>>> sv/eas_feast_dates.sv
module eas_feast_dates import eas_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  eas_easter_t in_easter,
    output logic        out_valid,
    input  logic        out_ready,
    output eas_feasts_t out_feasts
);

    localparam int NST    = 4;
    localparam int NFEAST = 4;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    logic [7:0]         doy_s0_reg;
    eas_easter_t        easter_s0_reg;
    logic [7:0]         off_s1_reg [NFEAST];
    eas_easter_t        easter_s1_reg;
    logic [7:0]         off_s2_reg [NFEAST];
    logic [MONTH_W-1:0] mon_s2_reg [NFEAST];
    eas_easter_t        easter_s2_reg;
    eas_feasts_t        feasts_s3_reg;

    logic [7:0]   doy_next;
    logic [7:0]   off_next [NFEAST];
    logic [DAY_W-1:0] day_next [NFEAST];
    eas_feasts_t  feasts_next;

    always_comb begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready   = rdy[0];
    assign out_valid  = v_reg[NST-1];
    assign out_feasts = feasts_s3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (rdy[k]) begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // easter as a day of the year
    assign doy_next = 8'(in_easter.day) + 8'd59 + 8'(in_easter.leap)
                    + ((in_easter.month == MONTH_APRIL) ? 8'd31 : 8'd0);

    // feast offsets from easter
    assign off_next[0] = doy_s0_reg - 8'd49;
    assign off_next[1] = doy_s0_reg - 8'd2;
    assign off_next[2] = doy_s0_reg + 8'd39;
    assign off_next[3] = doy_s0_reg + 8'd49;

    // day within the month found in the stage before
    always_comb begin
        for (int j = 0; j < NFEAST; j++) begin
            day_next[j] = DAY_W'(9'(off_s2_reg[j])
                        - days_before(mon_s2_reg[j], easter_s2_reg.leap));
        end
        feasts_next.carnival.month    = mon_s2_reg[0];
        feasts_next.carnival.day      = day_next[0];
        feasts_next.holy_friday.month = mon_s2_reg[1];
        feasts_next.holy_friday.day   = day_next[1];
        feasts_next.easter.month      = easter_s2_reg.month;
        feasts_next.easter.day        = easter_s2_reg.day;
        feasts_next.ascension.month   = mon_s2_reg[2];
        feasts_next.ascension.day     = day_next[2];
        feasts_next.whitsun.month     = mon_s2_reg[3];
        feasts_next.whitsun.day       = day_next[3];
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            doy_s0_reg    <= doy_next;
            easter_s0_reg <= in_easter;
        end
        if (rdy[1]) begin
            for (int j = 0; j < NFEAST; j++) begin
                off_s1_reg[j] <= off_next[j];
            end
            easter_s1_reg <= easter_s0_reg;
        end
        // month lookup against the cumulative month lengths
        if (rdy[2]) begin
            for (int j = 0; j < NFEAST; j++) begin
                off_s2_reg[j] <= off_s1_reg[j];
                mon_s2_reg[j] <= month_of(off_s1_reg[j], easter_s1_reg.leap);
            end
            easter_s2_reg <= easter_s1_reg;
        end
        if (rdy[3]) begin
            feasts_s3_reg <= feasts_next;
        end
    end

    a_carnival_month: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_feasts.carnival.month != 4'd0
                       && out_feasts.carnival.month <= MONTH_MARCH))
        else $error("carnival month out of range");

    a_holy_friday_month: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_feasts.holy_friday.month == MONTH_MARCH
                       || out_feasts.holy_friday.month == MONTH_APRIL))
        else $error("holy friday month out of range");

    a_ascension_month: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_feasts.ascension.month == MONTH_APRIL
                       || out_feasts.ascension.month == MONTH_MAY
                       || out_feasts.ascension.month == MONTH_JUNE))
        else $error("ascension month out of range");

    a_whitsun_month: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_feasts.whitsun.month == MONTH_MAY
                       || out_feasts.whitsun.month == MONTH_JUNE))
        else $error("whitsun month out of range");

endmodule

>>> bench/tb_easter_feast_dates_unit.sv
`timescale 1ns / 100ps

module tb_easter_feast_dates_unit;
    import eas_pkg::*;

    localparam int RANDOM_YEARS = 1750;
    localparam int DIR_ROWS     = 22;
    localparam int STALL_CYCLES = 80;
    localparam int DRAIN_CYCLES = 30;

    typedef struct {
        logic [YEAR_W-1:0] year;
        eas_feasts_t       dates;
    } pending_year_t;

    typedef struct {
        logic [YEAR_W-1:0] year;
        bit                typed;
        eas_feasts_t       dates;
    } year_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    pending_year_t pending_feasts[$];
    year_row_t     dir_table[DIR_ROWS];

    int  tx_idle_pct   = 0;
    int  rx_idle_pct   = 0;
    int  mismatches    = 0;
    int  results_seen  = 0;
    int  years_sent    = 0;
    int  leap_years    = 0;
    int  early_years   = 0;
    bit  stall_request = 1'b0;
    bit  rx_hold       = 1'b0;
    bit  input_stalled = 1'b0;

    string feast_name[5] = '{"carnival", "holy friday", "easter", "ascension", "whitsun"};

    easter_feast_dates_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always #4 aclk = ~aclk;

    // gregorian leap rule
    function automatic bit is_leap(input int unsigned year);
        if (year % 100 == 0) begin
            return (year % 400) == 0;
        end
        return (year % 4) == 0;
    endfunction

    function automatic int unsigned month_days(input int unsigned year, input int unsigned month);
        case (month)
            2:             return is_leap(year) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // day of the year back to month and day, with the day clamped to 1..31
    function automatic eas_date_t doy_to_date(input int unsigned year, input int unsigned doy);
        int unsigned month;
        eas_date_t   date;
        month = 1;
        while (month < 12 && doy > month_days(year, month)) begin
            doy   = doy - month_days(year, month);
            month = month + 1;
        end
        if (doy == 0) begin
            doy = 1;
        end
        if (doy > 31) begin
            doy = 31;
        end
        date.month = MONTH_W'(month);
        date.day   = DAY_W'(doy);
        return date;
    endfunction

    // anonymous computus, then the four offset feasts
    function automatic eas_feasts_t predict_feasts(input logic [YEAR_W-1:0] year_in);
        int unsigned y, a, b, c, d, e, f, g, h, i, k, l, m, base;
        int unsigned emonth, eday, doy;
        eas_feasts_t dates;
        y = year_in;
        a = y % 19;
        b = y / 100;
        c = y % 100;
        d = b / 4;
        e = b % 4;
        f = (b + 8) / 25;
        g = (b - f + 1) / 3;
        h = (19 * a + b - d - g + 15) % 30;
        i = c / 4;
        k = c % 4;
        l = (32 + 2 * e + 2 * i - h - k) % 7;
        m = (a + 11 * h + 22 * l) / 451;
        base   = h + l + 114 - 7 * m;
        emonth = base / 31;
        eday   = (base % 31) + 1;
        doy    = eday;
        for (int unsigned mo = 1; mo < emonth && mo <= 12; mo++) begin
            doy = doy + month_days(y, mo);
        end
        dates.carnival      = doy_to_date(y, doy - 49);
        dates.holy_friday   = doy_to_date(y, doy - 2);
        dates.easter.month  = MONTH_W'(emonth);
        dates.easter.day    = DAY_W'(eday);
        dates.ascension     = doy_to_date(y, doy + 39);
        dates.whitsun       = doy_to_date(y, doy + 49);
        return dates;
    endfunction

    // five dates typed in month, day order
    function automatic eas_feasts_t feast_set(input int cm, cd, gm, gd, em, ed, am, ad, wm, wd);
        eas_feasts_t dates;
        dates.carnival    = '{day: DAY_W'(cd), month: MONTH_W'(cm)};
        dates.holy_friday = '{day: DAY_W'(gd), month: MONTH_W'(gm)};
        dates.easter      = '{day: DAY_W'(ed), month: MONTH_W'(em)};
        dates.ascension   = '{day: DAY_W'(ad), month: MONTH_W'(am)};
        dates.whitsun     = '{day: DAY_W'(wd), month: MONTH_W'(wm)};
        return dates;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // compare one result item with the oldest pending year
    task automatic check_result(input eas_feasts_t got);
        pending_year_t want;
        eas_date_t     got_d[5];
        eas_date_t     want_d[5];
        results_seen++;
        if (pending_feasts.size() == 0) begin
            report_mismatch("result item with no year pending");
        end else begin
            want   = pending_feasts.pop_front();
            got_d  = '{got.carnival, got.holy_friday, got.easter, got.ascension, got.whitsun};
            want_d = '{want.dates.carnival, want.dates.holy_friday, want.dates.easter,
                       want.dates.ascension, want.dates.whitsun};
            for (int n = 0; n < 5; n++) begin
                if (got_d[n].month !== want_d[n].month) begin
                    report_mismatch($sformatf("year %0d %s month got %0d want %0d",
                                    want.year, feast_name[n], got_d[n].month, want_d[n].month));
                end
                if (got_d[n].day !== want_d[n].day) begin
                    report_mismatch($sformatf("year %0d %s day got %0d want %0d",
                                    want.year, feast_name[n], got_d[n].day, want_d[n].day));
                end
            end
        end
    endtask

    // offer one year, with a random gap first, and wait for it to be taken
    task automatic send_year(input logic [YEAR_W-1:0] year, input bit typed,
                             input eas_feasts_t typed_dates);
        pending_year_t entry;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, year};
        do @(posedge aclk); while (!s_tready);
        entry.year  = year;
        entry.dates = typed ? typed_dates : predict_feasts(year);
        pending_feasts.push_back(entry);
        years_sent++;
        if (is_leap(year)) begin
            leap_years++;
        end
        if (year < 14'd1583) begin
            early_years++;
        end
    endtask

    function automatic logic [YEAR_W-1:0] random_year();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            return YEAR_W'($urandom_range(16383, 1583));
        end else if (pick < 75) begin
            return YEAR_W'($urandom_range(2600, 1583));
        end else if (pick < 82) begin
            // centuries exercise the leap exception
            return YEAR_W'(100 * $urandom_range(163, 16));
        end
        return YEAR_W'($urandom_range(16383, 0));
    endfunction

    // result side: check, then pick the next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            check_result(eas_feasts_t'(m_tdata[44:0]));
        end
        if (rx_hold && !s_tready) begin
            input_stalled = 1'b1;
        end
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // long receiver hold-off, counted here
    initial begin
        while (!stall_request) @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb_easter_feast_dates_unit: done, errors");
        $finish;
    end

    // stimulus
    initial begin
        dir_table = '{
            '{14'd2024,  1'b1, feast_set(2, 11, 3, 29, 3, 31, 5,  9, 5, 19)},
            '{14'd2000,  1'b1, feast_set(3,  5, 4, 21, 4, 23, 6,  1, 6, 11)},
            '{14'd1818,  1'b1, feast_set(2,  1, 3, 20, 3, 22, 4, 30, 5, 10)},
            '{14'd1943,  1'b1, feast_set(3,  7, 4, 23, 4, 25, 6,  3, 6, 13)},
            '{14'd0,     1'b0, '0},
            '{14'd1,     1'b0, '0},
            '{14'd1582,  1'b0, '0},
            '{14'd1583,  1'b0, '0},
            '{14'd16383, 1'b0, '0},
            '{14'd16382, 1'b0, '0},
            '{14'd1600,  1'b0, '0},
            '{14'd1900,  1'b0, '0},
            '{14'd2100,  1'b0, '0},
            '{14'd2285,  1'b0, '0},
            '{14'd2038,  1'b0, '0},
            '{14'd1954,  1'b0, '0},
            '{14'd1981,  1'b0, '0},
            '{14'd2049,  1'b0, '0},
            '{14'd2076,  1'b0, '0},
            '{14'd8191,  1'b0, '0},
            '{14'd8192,  1'b0, '0},
            '{14'd10922, 1'b0, '0}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed rows and first random third: sender rarely idle, receiver mostly idle
        tx_idle_pct = 12;
        rx_idle_pct = 85;
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_year(dir_table[r].year, dir_table[r].typed, dir_table[r].dates);
        end
        for (int n = 0; n < RANDOM_YEARS / 3; n++) begin
            send_year(random_year(), 1'b0, '0);
        end

        // second third: the other way round
        tx_idle_pct = 85;
        rx_idle_pct = 12;
        for (int n = 0; n < RANDOM_YEARS / 3; n++) begin
            send_year(random_year(), 1'b0, '0);
        end

        // last third: no idling, with one long receiver stall up front
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        stall_request = 1'b1;
        for (int n = 0; n < RANDOM_YEARS - 2 * (RANDOM_YEARS / 3); n++) begin
            send_year(random_year(), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending_feasts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("years offered %0d (%0d leap, %0d before 1583), results checked %0d",
                 years_sent, leap_years, early_years, results_seen);
        $display("idle mixes on both sides covered, input back-pressure during long stall: %0s",
                 input_stalled ? "seen" : "not seen");
        if (mismatches == 0) begin
            $display("tb_easter_feast_dates_unit: done, clean");
        end else begin
            $display("tb_easter_feast_dates_unit: done, errors");
        end
        $finish;
    end

endmodule
